// ----- src/e2e_p4_pkg.sv -----
// ============================================================================
// e2e_p4_pkg: shared constants and functions for the profile 4 receive check
// Status codes, state-machine codes, register indexes, the CRC-32P4 byte step
// and the status mapping.
// ============================================================================
`default_nettype none

package e2e_p4_pkg;

    localparam int unsigned MAX_MSG_BYTES = 4096;
    localparam int unsigned CNT_W         = $clog2(MAX_MSG_BYTES + 1);
    localparam int unsigned HDR_BYTES     = 12;

    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 32;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_HEADER_OFFSET = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_LENGTH    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_LENGTH    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_DATA_ID       = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_DELTA     = 3'd4;

    // check status codes
    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_SOMELOST = 3'd1;
    localparam logic [2:0] ST_ERROR    = 3'd2;
    localparam logic [2:0] ST_REPEATED = 3'd3;
    localparam logic [2:0] ST_NONEW    = 3'd4;
    localparam logic [2:0] ST_WRONGSEQ = 3'd5;

    // state-machine status codes
    localparam logic [2:0] SM_OK       = 3'd0;
    localparam logic [2:0] SM_REPEATED = 3'd1;
    localparam logic [2:0] SM_WRONGSEQ = 3'd2;
    localparam logic [2:0] SM_ERROR    = 3'd3;
    localparam logic [2:0] SM_NONEW    = 3'd4;

    localparam logic [31:0] CRC_POLY_REFL = 32'hC8DF_352F;
    localparam logic [31:0] CRC_INIT      = 32'hFFFF_FFFF;
    localparam logic [31:0] CRC_XOR_OUT   = 32'hFFFF_FFFF;
    localparam logic [15:0] COUNTER_INIT  = 16'hFFFF;

    typedef logic [CNT_W-1:0] byte_cnt_t;

    // one reflected CRC-32P4 step over a byte
    function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
        logic [31:0] c;
        c = crc ^ {24'd0, b};
        for (int i = 0; i < 8; i++) begin
            if (c[0])
                c = (c >> 1) ^ CRC_POLY_REFL;
            else
                c = c >> 1;
        end
        return c;
    endfunction

    function automatic logic [2:0] map_to_sm(input logic [2:0] st);
        logic [2:0] sm;
        unique case (st)
            ST_OK, ST_SOMELOST: sm = SM_OK;
            ST_REPEATED:        sm = SM_REPEATED;
            ST_WRONGSEQ:        sm = SM_WRONGSEQ;
            ST_NONEW:           sm = SM_NONEW;
            default:            sm = SM_ERROR;
        endcase
        return sm;
    endfunction

endpackage

`default_nettype wire

// ----- src/e2e_profile4_check_top.sv -----
// ============================================================================
// e2e_profile4_check_top: E2E profile 4 receive check
// Takes a message one byte per word, captures the header, runs the CRC and
// reports a check status at the final byte or at a no-new-data word.
// ============================================================================
//
//   channel   direction  handshake             payload
//   -------   ---------  --------------------  ---------------------------------
//   in        input      in_valid / in_ready   cmd, data_byte, last
//   out       output     out_valid / out_ready return_code, check_status,
//                                              sm_status
//   cfg       input      cfg_write_en          cfg_index, cfg_data
//
// One input word per cycle while in_ready is high. The whole byte step
// (header capture, CRC step, final checks) sits between the state registers
// and the result register, so a result appears in the cycle after its word
// is accepted. in_ready drops only while a result waits in the output
// register and out_ready is low. Reset returns the configuration to its
// defaults and the status to error; no clearing pass is needed.
`default_nettype none

module e2e_profile4_check_top (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    // configuration
    input  wire logic                                cfg_write_en,
    input  wire logic [e2e_p4_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [e2e_p4_pkg::CFG_DATA_W-1:0]   cfg_data,
    // input words
    input  wire logic                                in_valid,
    output logic                                     in_ready,
    input  wire logic                                cmd,
    input  wire logic [7:0]                          data_byte,
    input  wire logic                                last,
    // results
    output logic                                     out_valid,
    input  wire logic                                out_ready,
    output logic                                     return_code,
    output logic [2:0]                               check_status,
    output logic [2:0]                               sm_status
);
    import e2e_p4_pkg::*;

    // configuration registers
    logic [11:0] header_offset_reg;
    logic [12:0] min_length_reg;
    logic [12:0] max_length_reg;
    logic [31:0] data_id_reg;
    logic [14:0] max_delta_reg;

    // message state
    logic [31:0] crc_reg,          crc_next;
    byte_cnt_t   byte_count_reg,   byte_count_next;
    logic [15:0] got_length_reg,   got_length_next;
    logic [15:0] got_counter_reg,  got_counter_next;
    logic [31:0] got_data_id_reg,  got_data_id_next;
    logic [31:0] got_crc_reg,      got_crc_next;
    logic [15:0] last_counter_reg, last_counter_next;
    logic [2:0]  status_reg,       status_next;

    // result register
    logic        out_valid_reg,    out_valid_next;
    logic        rc_reg,           rc_next;
    logic [2:0]  chk_reg,          chk_next;
    logic [2:0]  sm_reg,           sm_next;

    logic        accept;

    // byte step intermediates
    logic        cnt_room;
    byte_cnt_t   hdr_end;
    byte_cnt_t   rel;
    logic        in_hdr;
    logic        in_crc_field;
    logic [31:0] crc_step;
    byte_cnt_t   cnt_step;
    logic [15:0] len_step;
    logic [15:0] ctr_step;
    logic [31:0] id_step;
    logic [31:0] gcrc_step;
    logic        len_bad;
    logic        too_short;
    logic        mismatch;
    logic [15:0] delta;

    assign in_ready = !out_valid_reg || out_ready;
    assign accept   = in_valid && in_ready;

    assign out_valid    = out_valid_reg;
    assign return_code  = rc_reg;
    assign check_status = chk_reg;
    assign sm_status    = sm_reg;

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            header_offset_reg <= '0;
            min_length_reg    <= 13'(HDR_BYTES);
            max_length_reg    <= 13'(MAX_MSG_BYTES);
            data_id_reg       <= '0;
            max_delta_reg     <= 15'd1;
        end
        else if (cfg_write_en)
        begin
            unique case (cfg_index)
                REG_HEADER_OFFSET: header_offset_reg <= cfg_data[11:0];
                REG_MIN_LENGTH:    min_length_reg    <= cfg_data[12:0];
                REG_MAX_LENGTH:    max_length_reg    <= cfg_data[12:0];
                REG_DATA_ID:       data_id_reg       <= cfg_data;
                REG_MAX_DELTA:     max_delta_reg     <= cfg_data[14:0];
                default:           ;
            endcase
        end
    end

    // byte step: header capture and CRC
    always_comb
    begin
        cnt_room     = byte_count_reg < CNT_W'(MAX_MSG_BYTES);
        hdr_end      = CNT_W'(header_offset_reg) + CNT_W'(HDR_BYTES);
        rel          = byte_count_reg - CNT_W'(header_offset_reg);
        in_hdr       = cnt_room && (byte_count_reg >= CNT_W'(header_offset_reg))
                       && (byte_count_reg < hdr_end);
        in_crc_field = in_hdr && (rel >= CNT_W'(8));

        len_step  = got_length_reg;
        ctr_step  = got_counter_reg;
        id_step   = got_data_id_reg;
        gcrc_step = got_crc_reg;
        if (in_hdr)
        begin
            if (rel < CNT_W'(2))
                len_step = {got_length_reg[7:0], data_byte};
            else if (rel < CNT_W'(4))
                ctr_step = {got_counter_reg[7:0], data_byte};
            else if (rel < CNT_W'(8))
                id_step = {got_data_id_reg[23:0], data_byte};
            else
                gcrc_step = {got_crc_reg[23:0], data_byte};
        end

        crc_step = in_crc_field ? crc_reg : crc_byte(crc_reg, data_byte);
        cnt_step = cnt_room ? byte_count_reg + CNT_W'(1) : byte_count_reg;

        // final checks on the completed message
        len_bad   = (cnt_step < min_length_reg) || (cnt_step > max_length_reg);
        too_short = cnt_step < hdr_end;
        mismatch  = (gcrc_step != (crc_step ^ CRC_XOR_OUT))
                    || (id_step != data_id_reg)
                    || (len_step != 16'(cnt_step));
        delta     = ctr_step - last_counter_reg;
    end

    always_comb
    begin
        crc_next          = crc_reg;
        byte_count_next   = byte_count_reg;
        got_length_next   = got_length_reg;
        got_counter_next  = got_counter_reg;
        got_data_id_next  = got_data_id_reg;
        got_crc_next      = got_crc_reg;
        last_counter_next = last_counter_reg;
        status_next       = status_reg;

        out_valid_next = out_valid_reg && !out_ready;
        rc_next        = rc_reg;
        chk_next       = chk_reg;
        sm_next        = sm_reg;

        if (accept)
        begin
            if (cmd)
            begin
                // drop any partial message
                crc_next         = CRC_INIT;
                byte_count_next  = '0;
                got_length_next  = '0;
                got_counter_next = '0;
                got_data_id_next = '0;
                got_crc_next     = '0;
                status_next      = ST_NONEW;
                out_valid_next   = 1'b1;
                rc_next          = 1'b0;
                chk_next         = ST_NONEW;
                sm_next          = SM_NONEW;
            end
            else if (!last)
            begin
                crc_next         = crc_step;
                byte_count_next  = cnt_step;
                got_length_next  = len_step;
                got_counter_next = ctr_step;
                got_data_id_next = id_step;
                got_crc_next     = gcrc_step;
            end
            else
            begin
                if (len_bad)
                    status_next = status_reg;
                else if (too_short || mismatch)
                    status_next = ST_ERROR;
                else
                begin
                    if (delta > 16'(max_delta_reg))
                        status_next = ST_WRONGSEQ;
                    else if (delta == 16'd0)
                        status_next = ST_REPEATED;
                    else if (delta == 16'd1)
                        status_next = ST_OK;
                    else
                        status_next = ST_SOMELOST;
                    last_counter_next = ctr_step;
                end

                crc_next         = CRC_INIT;
                byte_count_next  = '0;
                got_length_next  = '0;
                got_counter_next = '0;
                got_data_id_next = '0;
                got_crc_next     = '0;

                out_valid_next = 1'b1;
                rc_next        = len_bad;
                chk_next       = status_next;
                sm_next        = len_bad ? SM_ERROR : map_to_sm(status_next);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            crc_reg          <= CRC_INIT;
            byte_count_reg   <= '0;
            got_length_reg   <= '0;
            got_counter_reg  <= '0;
            got_data_id_reg  <= '0;
            got_crc_reg      <= '0;
            last_counter_reg <= COUNTER_INIT;
            status_reg       <= ST_ERROR;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            crc_reg          <= crc_next;
            byte_count_reg   <= byte_count_next;
            got_length_reg   <= got_length_next;
            got_counter_reg  <= got_counter_next;
            got_data_id_reg  <= got_data_id_next;
            got_crc_reg      <= got_crc_next;
            last_counter_reg <= last_counter_next;
            status_reg       <= status_next;
            out_valid_reg    <= out_valid_next;
        end
    end

    // result payload, no reset
    always_ff @(posedge clk)
    begin
        rc_reg  <= rc_next;
        chk_reg <= chk_next;
        sm_reg  <= sm_next;
    end

endmodule

`default_nettype wire

// ----- src/e2e_p4_checker.sv -----
// ============================================================================
// e2e_p4_checker: port-level checks for the profile 4 receive check
// Watches the top-level ports and flags handshake and status slips.
// ============================================================================
`default_nettype none

module e2e_p4_checker (
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       in_valid,
    input wire logic       in_ready,
    input wire logic       cmd,
    input wire logic       out_valid,
    input wire logic       out_ready,
    input wire logic       return_code,
    input wire logic [2:0] check_status,
    input wire logic [2:0] sm_status
);
    import e2e_p4_pkg::*;

    // a stalled result word holds
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(check_status)
            && $stable(sm_status) && $stable(return_code))
        else $error("result word changed while stalled");

    // a no-new-data word gives its result in the next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && cmd |=> out_valid && check_status == ST_NONEW
            && sm_status == SM_NONEW && !return_code)
        else $error("no-new-data word did not report no new data");

    // a length fault always maps to error
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && return_code |-> sm_status == SM_ERROR)
        else $error("length fault without error status");

    // mapped status agrees with the check status when the length is fine
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !return_code |-> sm_status == map_to_sm(check_status))
        else $error("mapped status does not match check status");

endmodule

bind e2e_profile4_check_top e2e_p4_checker u_e2e_p4_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .cmd          (cmd),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .return_code  (return_code),
    .check_status (check_status),
    .sm_status    (sm_status)
);

`default_nettype wire

// ----- test/tb.sv -----
// ============================================================================
// tb: self-checking bench for the E2E profile 4 receive check
// Feeds whole messages one byte per word, well-formed ones with random
// payload and counter steps, plus corrupted, truncated, out-of-range and
// no-new-data words. An in-bench status predictor keeps its own copy of the
// registers, header capture and CRC. Each result word is checked against the
// oldest prediction. Both sides idle at random, and the registers change
// between phases while the block is idle.
// ============================================================================
`default_nettype none

module tb;

    import e2e_p4_pkg::*;

    typedef struct packed {
        logic       rc;
        logic [2:0] status;
        logic [2:0] sm;
    } status_word_t;

    // predicts the result word of every accepted last or no-new-data word and checks results
    class e2e_status_predictor;
        logic [11:0]    hdr_offset;
        logic [12:0]    min_len;
        logic [12:0]    max_len;
        logic [31:0]    exp_id;
        logic [14:0]    max_delta;

        logic [31:0]    crc;
        logic [12:0]    nbytes;
        logic [15:0]    rx_len;
        logic [15:0]    rx_ctr;
        logic [31:0]    rx_id;
        logic [31:0]    rx_crc;
        logic [15:0]    prev_ctr;
        logic [2:0]     status;

        status_word_t   expected_status[$];
        int unsigned    n_errors;
        int unsigned    n_checked;
        int unsigned    tally[6];
        int unsigned    len_rejects;

        function new();
            hdr_offset  = '0;
            min_len     = 13'd12;
            max_len     = 13'd4096;
            exp_id      = '0;
            max_delta   = 15'd1;
            prev_ctr    = COUNTER_INIT;
            status      = ST_ERROR;
            n_errors    = 0;
            n_checked   = 0;
            len_rejects = 0;
            foreach (tally[i])
                tally[i] = 0;
            clear_msg();
        endfunction

        function void clear_msg();
            crc    = CRC_INIT;
            nbytes = '0;
            rx_len = '0;
            rx_ctr = '0;
            rx_id  = '0;
            rx_crc = '0;
        endfunction

        // reflected CRC-32P4, one input bit at a time
        function logic [31:0] crc_step(input logic [31:0] c, input logic [7:0] b);
            logic [31:0] r;
            logic        fb;
            r = c;
            for (int k = 0; k < 8; k++)
            begin
                fb = r[0] ^ b[k];
                r  = r >> 1;
                if (fb)
                    r = r ^ CRC_POLY_REFL;
            end
            return r;
        endfunction

        function logic [2:0] sm_of(input logic [2:0] st);
            case (st)
                ST_OK, ST_SOMELOST: return SM_OK;
                ST_REPEATED:        return SM_REPEATED;
                ST_WRONGSEQ:        return SM_WRONGSEQ;
                ST_NONEW:           return SM_NONEW;
                default:            return SM_ERROR;
            endcase
        endfunction

        function void set_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] val);
            case (idx)
                REG_HEADER_OFFSET: hdr_offset = val[11:0];
                REG_MIN_LENGTH:    min_len    = val[12:0];
                REG_MAX_LENGTH:    max_len    = val[12:0];
                REG_DATA_ID:       exp_id     = val;
                REG_MAX_DELTA:     max_delta  = val[14:0];
                default:           ;
            endcase
        endfunction

        function void push_result(input logic rc);
            status_word_t w;
            w.rc     = rc;
            w.status = status;
            w.sm     = rc ? SM_ERROR : sm_of(status);
            expected_status.push_back(w);
            tally[status]++;
            if (rc)
                len_rejects++;
        endfunction

        function void note_word(input logic c, input logic [7:0] b, input logic l);
            int          pos;
            int          hdr_end;
            int          rel;
            logic        in_crc_field;
            logic        rc;
            logic [15:0] delta;
            pos     = int'(nbytes);
            hdr_end = int'(hdr_offset) + int'(HDR_BYTES);
            if (c)
            begin
                clear_msg();
                status = ST_NONEW;
                push_result(1'b0);
                return;
            end
            if (pos < int'(MAX_MSG_BYTES))
            begin
                in_crc_field = 1'b0;
                if (pos >= int'(hdr_offset) && pos < hdr_end)
                begin
                    rel = pos - int'(hdr_offset);
                    if (rel < 2)
                        rx_len = {rx_len[7:0], b};
                    else if (rel < 4)
                        rx_ctr = {rx_ctr[7:0], b};
                    else if (rel < 8)
                        rx_id = {rx_id[23:0], b};
                    else
                    begin
                        rx_crc = {rx_crc[23:0], b};
                        in_crc_field = 1'b1;
                    end
                end
                if (!in_crc_field)
                    crc = crc_step(crc, b);
                nbytes = nbytes + 13'd1;
            end
            else
                crc = crc_step(crc, b);
            if (!l)
                return;

            pos = int'(nbytes);
            rc  = 1'b0;
            if (pos < int'(min_len) || pos > int'(max_len))
                rc = 1'b1;
            else if (pos < hdr_end)
                status = ST_ERROR;
            else if (rx_crc != (crc ^ CRC_XOR_OUT) || rx_id != exp_id
                     || rx_len != {3'd0, nbytes})
                status = ST_ERROR;
            else
            begin
                delta = rx_ctr - prev_ctr;
                if (delta > {1'b0, max_delta})
                    status = ST_WRONGSEQ;
                else if (delta == 16'd0)
                    status = ST_REPEATED;
                else if (delta == 16'd1)
                    status = ST_OK;
                else
                    status = ST_SOMELOST;
                prev_ctr = rx_ctr;
            end
            push_result(rc);
            clear_msg();
        endfunction

        function void check_result(input logic rc, input logic [2:0] st, input logic [2:0] sm);
            status_word_t w;
            n_checked++;
            if (expected_status.size() == 0)
            begin
                $error("result word with nothing expected: %0d %0d %0d",
                       rc, st, sm);
                n_errors++;
                return;
            end
            w = expected_status.pop_front();
            if (rc !== w.rc)
            begin
                $error("return_code: expected %0d, actual %0d", w.rc, rc);
                n_errors++;
            end
            if (st !== w.status)
            begin
                $error("check_status: expected %0d, actual %0d", w.status, st);
                n_errors++;
            end
            if (sm !== w.sm)
            begin
                $error("sm_status: expected %0d, actual %0d", w.sm, sm);
                n_errors++;
            end
        endfunction

        function int pending();
            return expected_status.size();
        endfunction
    endclass

    logic                   clk;
    logic                   rst_n;
    logic                   cfg_write_en;
    logic [CFG_IDX_W-1:0]   cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;
    logic                   in_valid;
    logic                   in_ready;
    logic                   cmd;
    logic [7:0]             data_byte;
    logic                   last;
    logic                   out_valid;
    logic                   out_ready;
    logic                   return_code;
    logic [2:0]             check_status;
    logic [2:0]             sm_status;

    e2e_status_predictor    sb;
    logic [7:0]             msg_buf[$];
    logic                   send_burst;
    logic                   recv_burst;
    int unsigned            words_sent;
    int unsigned            settings_used;

    e2e_profile4_check_top dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write_en (cfg_write_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .cmd          (cmd),
        .data_byte    (data_byte),
        .last         (last),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .return_code  (return_code),
        .check_status (check_status),
        .sm_status    (sm_status)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #10_000_000;
        $display("Mismatches found");
        $finish;
    end

    // call at a falling edge; returns at the falling edge after acceptance
    task automatic send_word(input logic c, input logic [7:0] b, input logic l);
        int gap;
        gap = send_burst ? 0 : $urandom_range(0, 11);
        if (gap != 0)
        begin
            in_valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid  = 1'b1;
        cmd       = c;
        data_byte = b;
        last      = l;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        sb.note_word(c, b, l);
        words_sent++;
        @(negedge clk);
    endtask

    // hold input until every result is back, then let the pipe settle
    task automatic drain();
        in_valid = 1'b0;
        while (sb.pending() != 0)
            @(negedge clk);
        repeat (3) @(negedge clk);
    endtask

    task automatic configure(input int off, input int mn, input int mx,
                             input logic [31:0] id, input int dmax);
        logic [31:0] vals[5];
        logic [CFG_IDX_W-1:0] idxs[5];
        idxs = '{REG_HEADER_OFFSET, REG_MIN_LENGTH, REG_MAX_LENGTH,
                 REG_DATA_ID, REG_MAX_DELTA};
        vals = '{off, mn, mx, id, dmax};
        for (int k = 0; k < 5; k++)
        begin
            cfg_write_en = 1'b1;
            cfg_index    = idxs[k];
            cfg_data     = vals[k];
            sb.set_reg(idxs[k], vals[k]);
            @(negedge clk);
        end
        cfg_write_en = 1'b0;
        settings_used++;
    endtask

    // lay out a message with a valid header and CRC for the current offset
    task automatic build_msg(input int len, input logic [15:0] ctr,
                             input logic [31:0] id, input logic [15:0] lfield);
        logic [95:0] hdr;
        logic [31:0] c;
        int          off;
        off = int'(sb.hdr_offset);
        hdr = {lfield, ctr, id, 32'd0};
        msg_buf.delete();
        for (int i = 0; i < len; i++)
            msg_buf.push_back(8'($urandom_range(0, 255)));
        for (int r = 0; r < 12; r++)
            if (off + r < len)
                msg_buf[off + r] = hdr[95 - 8 * r -: 8];
        c = CRC_INIT;
        for (int i = 0; i < len; i++)
            if (!(i >= off + 8 && i < off + 12 && i < int'(MAX_MSG_BYTES)))
                c = sb.crc_step(c, msg_buf[i]);
        c = c ^ CRC_XOR_OUT;
        for (int r = 8; r < 12; r++)
            if (off + r < len)
                msg_buf[off + r] = c[31 - 8 * (r - 8) -: 8];
    endtask

    task automatic send_msg();
        for (int i = 0; i < msg_buf.size(); i++)
            send_word(1'b0, msg_buf[i], i == msg_buf.size() - 1);
    endtask

    task automatic good_msg(input int len, input logic [15:0] step);
        build_msg(len, sb.prev_ctr + step, sb.exp_id,
                  len > int'(MAX_MSG_BYTES) ? 16'(MAX_MSG_BYTES) : 16'(len));
        send_msg();
    endtask

    function automatic int pick_length();
        int off;
        int mn;
        int mx;
        int lo;
        int hi;
        int sel;
        off = int'(sb.hdr_offset);
        mn  = int'(sb.min_len);
        mx  = int'(sb.max_len);
        lo  = (mn > off + 12) ? mn : off + 12;
        hi  = (mx < off + 40) ? mx : off + 40;
        sel = $urandom_range(0, 19);
        if (sel < 2 && mn <= off + 11)
            return $urandom_range(mn, off + 11);
        else if (sel < 4 && mn > 1)
            return $urandom_range(1, mn - 1);
        else if (sel < 5 && mx < int'(MAX_MSG_BYTES))
            return $urandom_range(mx + 1, mx + 6);
        else if (lo <= hi)
            return $urandom_range(lo, hi);
        return $urandom_range(1, off + 40);
    endfunction

    function automatic logic [15:0] pick_step();
        case ($urandom_range(0, 9))
            0:       return 16'd0;
            1:       return {1'b0, sb.max_delta};
            2:       return {1'b0, sb.max_delta} + 16'd1;
            3:       return 16'($urandom_range(0, 65535));
            4, 5:    return 16'($urandom_range(2, 9));
            default: return 16'd1;
        endcase
    endfunction

    task automatic random_message();
        int          kind;
        int          len;
        int          cut;
        logic [31:0] id;
        logic [15:0] lfield;
        send_burst = ($urandom_range(0, 4) == 0);
        kind = $urandom_range(0, 99);
        if (kind < 6)
        begin
            send_word(1'b1, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
            return;
        end
        len    = pick_length();
        id     = sb.exp_id;
        lfield = 16'(len);
        if (kind < 12)
            id = id ^ (32'd1 << $urandom_range(0, 31));
        else if (kind < 18)
            lfield = lfield + 16'($urandom_range(1, 65535));
        build_msg(len, sb.prev_ctr + pick_step(), id, lfield);
        // flip one bit anywhere in the message
        if (kind >= 18 && kind < 26)
            msg_buf[$urandom_range(0, len - 1)] ^= 8'd1 << $urandom_range(0, 7);
        if (kind >= 26 && kind < 34)
        begin
            // abort the message partway with a no-new-data word
            cut = $urandom_range(0, len - 1);
            for (int i = 0; i < cut; i++)
                send_word(1'b0, msg_buf[i], 1'b0);
            send_word(1'b1, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
        end
        else
            send_msg();
    endtask

    // result side: random stall before each word, with runs of no stall
    initial
    begin
        int stall;
        out_ready  = 1'b0;
        recv_burst = 1'b0;
        @(posedge rst_n);
        @(negedge clk);
        forever
        begin
            if ($urandom_range(0, 19) == 0)
                recv_burst = ~recv_burst;
            stall = recv_burst ? 0 : $urandom_range(0, 11);
            if (stall != 0)
            begin
                out_ready = 1'b0;
                repeat (stall) @(negedge clk);
            end
            out_ready = 1'b1;
            @(posedge clk);
            while (!out_valid)
                @(posedge clk);
            sb.check_result(return_code, check_status, sm_status);
            @(negedge clk);
        end
    end

    initial
    begin
        int off;
        int mn;
        int mx;
        int dmax;
        sb            = new();
        rst_n         = 1'b0;
        cfg_write_en  = 1'b0;
        cfg_index     = '0;
        cfg_data      = '0;
        in_valid      = 1'b0;
        cmd           = 1'b0;
        data_byte     = '0;
        last          = 1'b0;
        send_burst    = 1'b0;
        words_sent    = 0;
        settings_used = 1;
        repeat (10) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // reset settings: no new data, good first message, too short, abort
        send_word(1'b1, 8'hFF, 1'b1);
        good_msg(12, 16'd1);
        send_word(1'b0, 8'h00, 1'b1);
        send_word(1'b0, 8'hFF, 1'b0);
        send_word(1'b0, 8'h5A, 1'b0);
        send_word(1'b0, 8'hA5, 1'b0);
        send_word(1'b1, 8'h00, 1'b0);
        drain();

        // exact length window, maximum counter delta of zero
        configure(0, 12, 12, 32'hFFFF_FFFF, 0);
        good_msg(12, 16'd0);
        good_msg(12, 16'd1);
        good_msg(13, 16'd1);
        drain();

        // inverted window rejects every length
        configure(0, 4096, 12, 32'd0, 1);
        good_msg(12, 16'd1);
        drain();

        while (words_sent < 1650)
        begin
            off = ($urandom_range(0, 3) == 0) ? $urandom_range(5, 24)
                                              : $urandom_range(0, 4);
            mn  = $urandom_range(12, off + 18);
            mx  = ($urandom_range(0, 5) == 0) ? int'(MAX_MSG_BYTES)
                                              : mn + $urandom_range(0, 40);
            case ($urandom_range(0, 5))
                0:       dmax = 0;
                1:       dmax = 1;
                2:       dmax = 32767;
                3:       dmax = $urandom_range(0, 32767);
                default: dmax = $urandom_range(2, 10);
            endcase
            configure(off, mn, mx, ($urandom_range(0, 7) == 0) ? 32'd0 : $urandom, dmax);
            repeat ($urandom_range(6, 16))
                random_message();
            drain();
        end

        $display("Ran %0d input words, %0d result words, %0d register settings",
                 words_sent, sb.n_checked, settings_used);
        $display("Statuses: ok %0d, some lost %0d, error %0d, repeated %0d,",
                 sb.tally[ST_OK], sb.tally[ST_SOMELOST], sb.tally[ST_ERROR],
                 sb.tally[ST_REPEATED]);
        $display("  no new data %0d, wrong sequence %0d; length rejects %0d",
                 sb.tally[ST_NONEW], sb.tally[ST_WRONGSEQ], sb.len_rejects);
        if (sb.n_errors == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

`default_nettype wire
